// ===== hdl/rtq_pkg.sv =====
`default_nettype none
package rtq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH   = 4;
    localparam int NUM_W         = 17;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [1:0]         branch_taken;
        logic               degenerate;
    } quat_t;

    typedef struct packed {
        logic [1:0]                  branch;
        logic                        degen;
        logic [1:0]                  diag;
        logic [3:0][NUM_W-1:0]       num;
    } rtq_meta_t;

endpackage
`default_nettype wire

// ===== hdl/rtq_front.sv =====
`default_nettype none
module rtq_front import rtq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SW        = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          mat_valid,
    output logic               mat_stall,
    input  wire mat_t          mat,
    output logic               push_valid,
    input  wire logic          push_full,
    output rtq_meta_t          push_meta,
    output logic [SW-1:0]      push_s
);

    localparam int SSW = SW + 1;
    localparam logic signed [SSW-1:0] ONE = SSW'(1) << FRAC_BITS;

    logic                  fr_valid_reg;
    rtq_meta_t             meta_reg, meta_next;
    logic [SW-1:0]         s_reg, s_next;
    logic                  load;

    logic signed [17:0]    tr;
    logic signed [SSW-1:0] s_val;
    logic [1:0]            axis;

    function automatic logic signed [SSW-1:0] sx(input logic [15:0] v);
        sx = {{(SSW-16){v[15]}}, v};
    endfunction

    function automatic logic [NUM_W-1:0] dif(input logic [15:0] a, input logic [15:0] b);
        dif = {a[15], a} - {b[15], b};
    endfunction

    function automatic logic [NUM_W-1:0] add(input logic [15:0] a, input logic [15:0] b);
        add = {a[15], a} + {b[15], b};
    endfunction

    always_comb
    begin
        tr = {{2{mat.m00[15]}}, mat.m00} + {{2{mat.m11[15]}}, mat.m11}
           + {{2{mat.m22[15]}}, mat.m22};
        axis = 2'd0;
        if (mat.m11 > mat.m00)
        begin
            axis = 2'd1;
        end
        if (mat.m22 > ((axis == 2'd1) ? mat.m11 : mat.m00))
        begin
            axis = 2'd2;
        end
        meta_next       = '0;
        meta_next.degen = 1'b0;
        if (tr > 18'sd0)
        begin
            s_val                  = SSW'(tr) + ONE;
            meta_next.branch       = BR_TRACE;
            meta_next.diag         = SLOT_W;
            meta_next.num[SLOT_X]  = dif(mat.m21, mat.m12);
            meta_next.num[SLOT_Y]  = dif(mat.m02, mat.m20);
            meta_next.num[SLOT_Z]  = dif(mat.m10, mat.m01);
        end
        else
        begin
            case (axis)
                2'd0:
                begin
                    s_val                 = sx(mat.m00) - sx(mat.m11) - sx(mat.m22) + ONE;
                    meta_next.branch      = BR_X;
                    meta_next.diag        = SLOT_X;
                    meta_next.num[SLOT_W] = dif(mat.m21, mat.m12);
                    meta_next.num[SLOT_Y] = add(mat.m10, mat.m01);
                    meta_next.num[SLOT_Z] = add(mat.m20, mat.m02);
                end
                2'd1:
                begin
                    s_val                 = sx(mat.m11) - sx(mat.m22) - sx(mat.m00) + ONE;
                    meta_next.branch      = BR_Y;
                    meta_next.diag        = SLOT_Y;
                    meta_next.num[SLOT_W] = dif(mat.m02, mat.m20);
                    meta_next.num[SLOT_Z] = add(mat.m21, mat.m12);
                    meta_next.num[SLOT_X] = add(mat.m01, mat.m10);
                end
                default:
                begin
                    s_val                 = sx(mat.m22) - sx(mat.m00) - sx(mat.m11) + ONE;
                    meta_next.branch      = BR_Z;
                    meta_next.diag        = SLOT_Z;
                    meta_next.num[SLOT_W] = dif(mat.m10, mat.m01);
                    meta_next.num[SLOT_X] = add(mat.m02, mat.m20);
                    meta_next.num[SLOT_Y] = add(mat.m12, mat.m21);
                end
            endcase
            meta_next.degen = s_val[SSW-1] || (s_val == '0);
        end
        s_next = s_val[SW-1:0];
    end

    assign mat_stall  = fr_valid_reg && push_full;
    assign load       = mat_valid && !mat_stall;
    assign push_valid = fr_valid_reg;
    assign push_meta  = meta_reg;
    assign push_s     = s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (!mat_stall)
        begin
            fr_valid_reg <= mat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meta_reg <= meta_next;
            s_reg    <= s_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rtq_queue.sv =====
`default_nettype none
module rtq_queue import rtq_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rtq_back.sv =====
`default_nettype none
module rtq_back import rtq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SW        = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    output logic               q_pop,
    input  wire rtq_meta_t     q_meta,
    input  wire logic [SW-1:0] q_s,
    output logic               quat_valid,
    input  wire logic          quat_stall,
    output quat_t              quat
);

    localparam int TW  = (SW + FRAC_BITS + 1) / 2;
    localparam int EW  = 2 * TW + 2;
    localparam int DA  = FRAC_BITS + NUM_W + 1;
    localparam int DB  = TW + 17;
    localparam int DW  = ((DA > DB) ? DA : DB) + 1;
    localparam int QB  = 16;
    localparam int P   = TW + 1;
    localparam int L   = TW + 1 + QB;

    logic            en;
    logic            v_reg [L+1];
    rtq_meta_t       m_reg [L+1];

    logic [EW-1:0]   sq_rem [TW+1];
    logic [TW-1:0]   sq_root [TW+1];

    logic [DW-1:0]   d_den [QB+1];
    logic [TW-1:0]   d_t   [QB+1];
    logic [DW-1:0]   d_rem [QB+1][4];
    logic [QB-1:0]   d_q   [QB+1][4];
    logic            d_neg [QB+1][4];
    logic            d_ovf [QB+1][4];

    logic            out_valid_reg;
    quat_t           out_reg, out_next;

    assign en        = !out_valid_reg || !quat_stall;
    assign q_pop     = en && !q_empty;
    assign v_reg[0]  = q_pop;
    assign m_reg[0]  = q_meta;
    assign sq_rem[0] = EW'(q_s) << FRAC_BITS;
    assign sq_root[0] = '0;

    genvar k, l;
    generate
        for (k = 1; k <= L; k++)
        begin : g_pipe
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[k] <= m_reg[k-1];
                end
            end
        end

        for (k = 1; k <= TW; k++)
        begin : g_sqrt
            localparam int B = TW - k;
            logic [EW-1:0] inc;
            logic          ge;
            assign inc = (EW'(sq_root[k-1]) << (B + 1)) + (EW'(1) << (2 * B));
            assign ge  = sq_rem[k-1] >= inc;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem[k]  <= ge ? sq_rem[k-1] - inc : sq_rem[k-1];
                    sq_root[k] <= ge ? (sq_root[k-1] | (TW'(1) << B)) : sq_root[k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_t[0]   <= sq_root[TW];
                d_den[0] <= DW'(sq_root[TW]) << 1;
            end
        end

        for (l = 0; l < 4; l++)
        begin : g_prep
            logic [NUM_W-1:0] n;
            logic [NUM_W-1:0] mag;
            logic [DW-1:0]    num;
            assign n   = m_reg[P-1].num[l];
            assign mag = n[NUM_W-1] ? (~n + 1'b1) : n;
            assign num = (DW'(mag) << FRAC_BITS) + DW'(sq_root[TW]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_rem[0][l] <= num;
                    d_q[0][l]   <= '0;
                    d_neg[0][l] <= n[NUM_W-1];
                    d_ovf[0][l] <= num >= ((DW'(sq_root[TW]) << 1) << QB);
                end
            end
        end

        for (k = 1; k <= QB; k++)
        begin : g_div
            localparam int B = QB - k;
            logic [DW-1:0] sh;
            assign sh = d_den[k-1] << B;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_den[k] <= d_den[k-1];
                    d_t[k]   <= d_t[k-1];
                end
            end
            for (l = 0; l < 4; l++)
            begin : g_lane
                logic ge;
                assign ge = d_rem[k-1][l] >= sh;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        d_rem[k][l] <= ge ? d_rem[k-1][l] - sh : d_rem[k-1][l];
                        d_q[k][l]   <= ge ? (d_q[k-1][l] | (QB'(1) << B)) : d_q[k-1][l];
                        d_neg[k][l] <= d_neg[k-1][l];
                        d_ovf[k][l] <= d_ovf[k-1][l];
                    end
                end
            end
        end
    endgenerate

    function automatic logic [15:0] sat_part(input logic neg, input logic ovf,
                                             input logic [QB-1:0] q);
        if (ovf)
        begin
            sat_part = neg ? 16'h8000 : 16'h7fff;
        end
        else if (neg)
        begin
            sat_part = (q > 16'h8000) ? 16'h8000 : 16'(~q + 1'b1);
        end
        else
        begin
            sat_part = (q > 16'h7fff) ? 16'h7fff : q;
        end
    endfunction

    logic [TW:0]  half;
    logic [15:0]  part [4];

    always_comb
    begin
        half = ({1'b0, d_t[QB]} + 1'b1) >> 1;
        for (int i = 0; i < 4; i++)
        begin
            if (m_reg[L].degen)
            begin
                part[i] = '0;
            end
            else if (m_reg[L].diag == 2'(i))
            begin
                part[i] = (half > (TW+1)'(32767)) ? 16'h7fff : 16'(half);
            end
            else
            begin
                part[i] = sat_part(d_neg[QB][i], d_ovf[QB][i], d_q[QB][i]);
            end
        end
        out_next.quat_x       = part[SLOT_X];
        out_next.quat_y       = part[SLOT_Y];
        out_next.quat_z       = part[SLOT_Z];
        out_next.quat_w       = part[SLOT_W];
        out_next.branch_taken = m_reg[L].branch;
        out_next.degenerate   = m_reg[L].degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[L];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v_reg[L])
        begin
            out_reg <= out_next;
        end
    end

    assign quat_valid = out_valid_reg;
    assign quat       = out_reg;

endmodule
`default_nettype wire

// ===== hdl/rotation_to_quaternion.sv =====
`default_nettype none
// Rotation matrix (nine Q2.14 elements) to quaternion, one matrix per cycle
// sustained while the result side does not stall. The front stage picks the
// branch and builds the root argument, a 4-deep queue decouples it from the
// arithmetic pipeline, which takes one root bit per stage and one quotient bit
// per stage for all parts at once. A stall on the result side halts only the
// arithmetic pipeline; matrices keep being taken until the queue fills.
module rotation_to_quaternion import rtq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  mat_valid,
    output logic       mat_stall,
    input  wire mat_t  mat,
    output logic       quat_valid,
    input  wire logic  quat_stall,
    output quat_t      quat
);

    localparam int SW = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
    localparam int QW = $bits(rtq_meta_t) + SW;

    logic            push_valid, push_full, q_empty, q_pop;
    rtq_meta_t       push_meta, q_meta;
    logic [SW-1:0]   push_s, q_s;
    logic [QW-1:0]   q_head;

    rtq_front #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat_stall  (mat_stall),
        .mat        (mat),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_meta  (push_meta),
        .push_s     (push_s)
    );

    rtq_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_meta, push_s}),
        .full      (push_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    assign q_meta = q_head[QW-1:SW];
    assign q_s    = q_head[SW-1:0];

    rtq_back #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_meta     (q_meta),
        .q_s        (q_s),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat       (quat)
    );

endmodule
`default_nettype wire

// ===== hdl/rtq_checker.sv =====
`default_nettype none
module rtq_checker import rtq_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  mat_valid,
    input wire logic  mat_stall,
    input wire mat_t  mat,
    input wire logic  quat_valid,
    input wire logic  quat_stall,
    input wire quat_t quat
);

    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_stall |=> mat_valid && $stable(mat))
        else $error("input beat changed under stall");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid)
        else $error("result beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> $stable(quat))
        else $error("result beat changed under stall");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat.degenerate |->
            (quat.quat_x == 16'sd0) && (quat.quat_y == 16'sd0) &&
            (quat.quat_z == 16'sd0) && (quat.quat_w == 16'sd0))
        else $error("degenerate beat with nonzero parts");

    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && (quat.branch_taken == BR_TRACE) |->
            !quat.degenerate && (quat.quat_w > 16'sd0))
        else $error("trace branch beat marked degenerate or w not positive");

endmodule

bind rotation_to_quaternion rtq_checker u_rtq_checker (.*);
`default_nettype wire
